// ===== rtl/smmac_pkg.sv =====
package smmac_pkg;

   // Field widths of the request and response transactions.
   localparam int OP_W    = 2;
   localparam int IDX_W   = 3;
   localparam int VALUE_W = 32;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD_C  = 2'd2;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd3;

   // Fraction bits of the Q16.16 format.
   localparam int FRAC_W = 16;

   // One queued command from the front end to the execution back end.
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

// ===== rtl/smmac_req_if.sv =====
interface smmac_req_if import smmac_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           req_type;
   logic [IDX_W-1:0]          row;
   logic [IDX_W-1:0]          col;
   logic signed [VALUE_W-1:0] elem_value;

   modport source (output valid, output req_type, output row, output col,
                   output elem_value, input ready);
   modport sink (input valid, input req_type, input row, input col,
                 input elem_value, output ready);
endinterface

// ===== rtl/smmac_rsp_if.sv =====
interface smmac_rsp_if import smmac_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [IDX_W-1:0]          out_row;
   logic [IDX_W-1:0]          out_col;
   logic signed [VALUE_W-1:0] out_value;
   logic                      saturated;
   logic                      last;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output saturated, output last, input ready);
   modport sink (input valid, input out_row, input out_col, input out_value,
                 input saturated, input last, output ready);
endinterface

// ===== rtl/smmac_ram.sv =====
module smmac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/smmac_front.sv =====
module smmac_front import smmac_pkg::*; #(
   parameter int MATRIX_SIZE = 4
) (
   input  logic        clock,
   input  logic        reset,
   smmac_req_if.sink   req_bus,
   output cmd_type     cmd,
   output logic        cmd_valid,
   input  logic        cmd_pop
);

   localparam int QUEUE_DEPTH = 2;

   cmd_type        entry_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           accept;
   logic           in_range;
   logic           push;
   logic           pop;

   // A transaction is taken whenever the queue has room.
   assign req_bus.ready = (count_ff != 2'(QUEUE_DEPTH));
   assign accept = req_bus.valid && req_bus.ready;

   // Loads outside the matrix are dropped here; compute always goes through.
   assign in_range = ({1'b0, req_bus.row} < 4'(MATRIX_SIZE)) &&
                     ({1'b0, req_bus.col} < 4'(MATRIX_SIZE));
   assign push = accept && ((req_bus.req_type == OP_COMPUTE) || in_range);
   assign pop  = cmd_pop && (count_ff != 2'd0);

   // Queue pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: req_bus.req_type, row: req_bus.row,
                                  col: req_bus.col, value: req_bus.elem_value};
      end
   end

   assign cmd       = entry_ff[rd_ptr_ff];
   assign cmd_valid = (count_ff != 2'd0);

endmodule

// ===== rtl/smmac_back.sv =====
module smmac_back import smmac_pkg::*; #(
   parameter int MATRIX_SIZE = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   smmac_rsp_if.source rsp_bus
);

   localparam int DEPTH  = MATRIX_SIZE * MATRIX_SIZE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = 2 * VALUE_W;
   localparam int ACC_W  = PROD_W + $clog2(MATRIX_SIZE + 1);
   localparam int TOP_LO = VALUE_W + FRAC_W - 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_SIZE - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MATRIX_SIZE + int'(c));
   endfunction

   logic                    state_ff, state_in;
   logic [IDX_W-1:0]        m_ff, m_in, n_ff, n_in, s_ff, s_in;
   logic                    adv, drained, start, issue, last_issue;

   // Pipeline tags: stage 1 is RAM data, stage 2 the product, stage 3 the sum.
   logic                    v1_ff, v2_ff, v3_ff;
   logic                    first1_ff, first2_ff;
   logic                    lastk1_ff, lastk2_ff, lastk3_ff;
   logic                    lastel1_ff, lastel2_ff, lastel3_ff;
   logic [IDX_W-1:0]        m1_ff, m2_ff, m3_ff, n1_ff, n2_ff, n3_ff;

   logic [VALUE_W-1:0]      a_rd, b_rd, c_rd;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic [VALUE_W-1:0]      c2_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base;

   logic [ACC_W-TOP_LO-1:0] acc_top;
   logic                    fits;
   logic [VALUE_W-1:0]      sat_value;
   logic                    wb_en;

   logic                    out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]        out_row_ff, out_col_ff;
   logic [VALUE_W-1:0]      out_value_ff;
   logic                    out_sat_ff, out_last_ff;

   logic                    a_we, b_we, c_we;
   logic [ADDR_W-1:0]       c_waddr;
   logic [VALUE_W-1:0]      c_wdata;

   // The whole datapath moves only when the output register can take a result.
   assign adv     = !out_valid_ff || rsp_bus.ready;
   assign drained = !v1_ff && !v2_ff && !v3_ff;
   assign start   = (state_ff == ST_IDLE) && cmd_valid && drained;
   assign cmd_pop = start;
   assign issue   = (state_ff == ST_RUN) && adv;
   assign last_issue = (m_ff == IDX_LAST) && (n_ff == IDX_LAST) && (s_ff == IDX_LAST);

   // Sequencer: loads complete in IDLE as they are popped; compute walks m, n, s.
   always_comb begin
      state_in = state_ff;
      m_in = m_ff;
      n_in = n_ff;
      s_in = s_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (cmd.op == OP_COMPUTE)) begin
               state_in = ST_RUN;
               m_in = '0;
               n_in = '0;
               s_in = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (s_ff != IDX_LAST) begin
                  s_in = s_ff + 1'b1;
               end else begin
                  s_in = '0;
                  if (n_ff != IDX_LAST) begin
                     n_in = n_ff + 1'b1;
                  end else begin
                     n_in = '0;
                     m_in = m_ff + 1'b1;
                  end
               end
               if (last_issue) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      m_ff <= m_in;
      n_ff <= n_in;
      s_ff <= s_in;
   end

   // Element stores.
   assign a_we = start && (cmd.op == OP_LOAD_A);
   assign b_we = start && (cmd.op == OP_LOAD_B);
   assign c_we = (start && (cmd.op == OP_LOAD_C)) || wb_en;
   assign c_waddr = wb_en ? cell_addr(m3_ff, n3_ff) : cell_addr(cmd.row, cmd.col);
   assign c_wdata = wb_en ? sat_value : cmd.value;

   smmac_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (cell_addr(cmd.row, cmd.col)),
      .wr_data (cmd.value),
      .rd_en   (issue),
      .rd_addr (cell_addr(m_ff, s_ff)),
      .rd_data (a_rd)
   );

   smmac_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (cell_addr(cmd.row, cmd.col)),
      .wr_data (cmd.value),
      .rd_en   (issue),
      .rd_addr (cell_addr(s_ff, n_ff)),
      .rd_data (b_rd)
   );

   smmac_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_c_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (issue),
      .rd_addr (cell_addr(m_ff, n_ff)),
      .rd_data (c_rd)
   );

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Full-width Q32.32 product and exact Q35.32 accumulation.
   assign prod_in  = $signed(a_rd) * $signed(b_rd);
   assign acc_base = first2_ff
                   ? {{(ACC_W-VALUE_W-FRAC_W){c2_ff[VALUE_W-1]}}, c2_ff, FRAC_W'(0)}
                   : acc_ff;
   assign acc_in   = acc_base + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         first1_ff  <= (s_ff == '0);
         lastk1_ff  <= (s_ff == IDX_LAST);
         lastel1_ff <= (m_ff == IDX_LAST) && (n_ff == IDX_LAST);
         m1_ff      <= m_ff;
         n1_ff      <= n_ff;

         first2_ff  <= first1_ff;
         lastk2_ff  <= lastk1_ff;
         lastel2_ff <= lastel1_ff;
         m2_ff      <= m1_ff;
         n2_ff      <= n1_ff;
         prod_ff    <= prod_in;
         c2_ff      <= c_rd;

         lastk3_ff  <= lastk2_ff;
         lastel3_ff <= lastel2_ff;
         m3_ff      <= m2_ff;
         n3_ff      <= n2_ff;
         if (v2_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Drop the low 16 fraction bits (floor to Q16.16) and clip to the signed 32-bit range.
   assign acc_top   = acc_ff[ACC_W-1:TOP_LO];
   assign fits      = (&acc_top) || !(|acc_top);
   assign sat_value = fits ? acc_ff[TOP_LO:FRAC_W]
                    : (acc_ff[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : {1'b0, {(VALUE_W-1){1'b1}}});
   assign wb_en     = adv && v3_ff && lastk3_ff;

   // Output register holds one finished element until it is taken.
   assign out_valid_in = adv ? wb_en : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (wb_en) begin
         out_row_ff   <= m3_ff;
         out_col_ff   <= n3_ff;
         out_value_ff <= sat_value;
         out_sat_ff   <= !fits;
         out_last_ff  <= lastel3_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.out_row   = out_row_ff;
   assign rsp_bus.out_col   = out_col_ff;
   assign rsp_bus.out_value = out_value_ff;
   assign rsp_bus.saturated = out_sat_ff;
   assign rsp_bus.last      = out_last_ff;

endmodule

// ===== rtl/small_matrix_multiply_accumulate_unit.sv =====
// Matrix multiply-accumulate for square MATRIX_SIZE by MATRIX_SIZE matrices in signed
// Q16.16. Request transactions load single elements of A, B or the initial C, and a
// compute transaction forms C += A*B, returning every element of C in row-major order
// with the final one marked last; the clipped result is written back, so a further
// compute accumulates again. Loads with a row or column outside the matrix are dropped.
// A two-entry queue takes one request per cycle while it has room. In the back end a
// load is written as it leaves the queue; a compute runs MATRIX_SIZE^3 multiply-adds
// on the single 32x32 multiplier, one per cycle while the back end is not held, then
// the read, multiply and accumulate stages drain before the next queued request starts.
// The whole back end holds while a finished result waits in the output register.
module small_matrix_multiply_accumulate_unit import smmac_pkg::*; #(
   parameter int MATRIX_SIZE = 4
) (
   input  logic        clock,
   input  logic        reset,
   smmac_req_if.sink   req_bus,
   smmac_rsp_if.source rsp_bus
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // Request intake and command queue.
   smmac_front #(.MATRIX_SIZE(MATRIX_SIZE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // Element stores, multiply-accumulate pipeline and result register.
   smmac_back #(.MATRIX_SIZE(MATRIX_SIZE)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== tb/sv/tb_small_matrix_multiply_accumulate_unit.sv =====
`timescale 1ns / 1ps

module tb_small_matrix_multiply_accumulate_unit;
   import smmac_pkg::*;

   localparam int N = 4;
   localparam int RANDOM_ITEMS = 32;

   localparam logic signed [VALUE_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] Q_MIN     = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] Q_ONE     = 32'sh0001_0000;
   localparam logic signed [VALUE_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;
   localparam logic signed [71:0] SUM_HI = 72'sd2147483647;
   localparam logic signed [71:0] SUM_LO = -72'sd2147483648;

   // One element of C as it should come back.
   typedef struct {
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
      logic                      sat;
      logic                      last;
   } c_elem_t;

   // One line of the directed sequence. A fill line loads every element of one matrix.
   typedef struct {
      bit                        fill;
      logic [OP_W-1:0]           op;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
      bit                        typed;
      logic signed [VALUE_W-1:0] want;
      bit                        want_sat;
   } plan_row_t;

   logic clock;
   logic reset;

   smmac_req_if req_ch ();
   smmac_rsp_if rsp_ch ();

   small_matrix_multiply_accumulate_unit #(.MATRIX_SIZE(N)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // Shadow copies of the three matrices and the C elements still to come back.
   logic signed [VALUE_W-1:0] a_elems [N*N];
   logic signed [VALUE_W-1:0] b_elems [N*N];
   logic signed [VALUE_W-1:0] c_elems [N*N];
   c_elem_t pending_elems [$];

   int  fail_count = 0;
   int  results_seen = 0;
   bit  sender_calm = 0;
   bit  long_hold_done = 0;

   logic [OP_W-1:0] load_ops [3] = '{OP_LOAD_A, OP_LOAD_B, OP_LOAD_C};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Update the shadow matrices for one transaction; a compute forms C += A*B exactly
   // in Q40.32, floors to Q16.16, clips, writes back and queues every element of C.
   function automatic void apply_request(input logic [OP_W-1:0] op,
                                         input logic [IDX_W-1:0] r,
                                         input logic [IDX_W-1:0] c,
                                         input logic signed [VALUE_W-1:0] v);
      logic signed [71:0] acc;
      logic signed [63:0] prod;
      c_elem_t e;
      if (op != OP_COMPUTE) begin
         if (r >= N || c >= N) return;
         case (op)
            OP_LOAD_A: a_elems[r*N + c] = v;
            OP_LOAD_B: b_elems[r*N + c] = v;
            default:   c_elems[r*N + c] = v;
         endcase
         return;
      end
      for (int m = 0; m < N; m++) begin
         for (int n = 0; n < N; n++) begin
            acc = c_elems[m*N + n];
            acc = acc <<< FRAC_W;
            for (int s = 0; s < N; s++) begin
               prod = a_elems[m*N + s] * b_elems[s*N + n];
               acc = acc + prod;
            end
            acc = acc >>> FRAC_W;
            e.sat = 1'b1;
            if (acc > SUM_HI) begin
               e.value = Q_MAX;
            end else if (acc < SUM_LO) begin
               e.value = Q_MIN;
            end else begin
               e.value = acc[VALUE_W-1:0];
               e.sat = 1'b0;
            end
            c_elems[m*N + n] = e.value;
            e.row = IDX_W'(m);
            e.col = IDX_W'(n);
            e.last = (m == N-1) && (n == N-1);
            pending_elems.push_back(e);
         end
      end
   endfunction

   // Random element value: mostly small Q16.16 numbers, some full range, some extremes.
   function automatic logic signed [VALUE_W-1:0] rand_value();
      logic signed [VALUE_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return raw >>> 13;
         4, 5:       return raw;
         6: begin
            case ($urandom_range(0, 4))
               0:       return Q_MIN;
               1:       return Q_MAX;
               2:       return '0;
               3:       return Q_ONE;
               default: return Q_NEG_ONE;
            endcase
         end
         default:    return raw >>> 24;
      endcase
   endfunction

   // Offer one request transaction, maybe after a short gap, and predict on acceptance.
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [IDX_W-1:0] r,
                               input logic [IDX_W-1:0] c,
                               input logic signed [VALUE_W-1:0] v,
                               input bit typed,
                               input logic signed [VALUE_W-1:0] want,
                               input bit want_sat);
      int first;
      if (!sender_calm && $urandom_range(0, 99) < 18) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= op;
      req_ch.row        <= r;
      req_ch.col        <= c;
      req_ch.elem_value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      first = pending_elems.size();
      apply_request(op, r, c, v);
      // Rows with a hand-typed answer replace the predicted value.
      if (typed) begin
         for (int i = first; i < pending_elems.size(); i++) begin
            pending_elems[i].value = want;
            pending_elems[i].sat   = want_sat;
         end
      end
   endtask

   // Stop offering and let every outstanding element of C come back.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare every accepted result transaction with the oldest expected element.
   always @(posedge clock) begin
      c_elem_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_elems.size() == 0) begin
            $error("unexpected result: row %0d col %0d value %h", rsp_ch.out_row,
                   rsp_ch.out_col, rsp_ch.out_value);
            fail_count++;
         end else begin
            want = pending_elems.pop_front();
            check_field("out_row", 32'(want.row), 32'(rsp_ch.out_row));
            check_field("out_col", 32'(want.col), 32'(rsp_ch.out_col));
            check_field("out_value", want.value, rsp_ch.out_value);
            check_field("saturated", 32'(want.sat), 32'(rsp_ch.saturated));
            check_field("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

   // Result side: random back-pressure, one long hold-off, and a window with none.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else if (results_seen >= 100 && results_seen < 150) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 18);
         end
      end
   end

   // Request side: reset, directed sequence, then random load/compute rounds.
   initial begin
      plan_row_t plan [28];
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      int random_items;
      int loads;
      bit paused;

      reset = 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= OP_LOAD_A;
      req_ch.row        <= '0;
      req_ch.col        <= '0;
      req_ch.elem_value <= '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan = '{
         // Zero product leaves C unchanged at one.
         '{1, OP_LOAD_A, 0, 0, '0,        0, '0, 0},
         '{1, OP_LOAD_B, 0, 0, '0,        0, '0, 0},
         '{1, OP_LOAD_C, 0, 0, Q_ONE,     0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       1, Q_ONE, 0},
         // Out-of-range loads are dropped; compute ignores its index fields.
         '{0, OP_LOAD_C, 4, 1, Q_MAX,     0, '0, 0},
         '{0, OP_LOAD_C, 1, 4, Q_MIN,     0, '0, 0},
         '{0, OP_LOAD_A, 7, 7, Q_MAX,     0, '0, 0},
         '{0, OP_COMPUTE, 7, 7, Q_MAX,    1, Q_ONE, 0},
         // One times minus one, summed over four terms.
         '{1, OP_LOAD_A, 0, 0, Q_ONE,     0, '0, 0},
         '{1, OP_LOAD_B, 0, 0, Q_NEG_ONE, 0, '0, 0},
         '{1, OP_LOAD_C, 0, 0, '0,        0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       1, 32'shFFFC_0000, 0},
         // Tiny negative products round toward minus infinity.
         '{1, OP_LOAD_A, 0, 0, 32'sh1,    0, '0, 0},
         '{1, OP_LOAD_B, 0, 0, -32'sh1,   0, '0, 0},
         '{1, OP_LOAD_C, 0, 0, '0,        0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       1, -32'sh1, 0},
         // Positive overflow clips to the maximum.
         '{1, OP_LOAD_A, 0, 0, Q_MAX,     0, '0, 0},
         '{1, OP_LOAD_B, 0, 0, Q_MAX,     0, '0, 0},
         '{1, OP_LOAD_C, 0, 0, Q_MAX,     0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       1, Q_MAX, 1},
         // Negative overflow clips to the minimum.
         '{1, OP_LOAD_B, 0, 0, Q_MIN,     0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       1, Q_MIN, 1},
         // Minimum squared overflows upward again.
         '{1, OP_LOAD_A, 0, 0, Q_MIN,     0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       1, Q_MAX, 1},
         // Single element updates, checked against the prediction.
         '{0, OP_LOAD_A, 3, 0, Q_ONE,     0, '0, 0},
         '{0, OP_LOAD_B, 0, 3, 32'sh0002_8000, 0, '0, 0},
         '{0, OP_LOAD_C, 2, 2, '0,        0, '0, 0},
         '{0, OP_COMPUTE, 0, 0, '0,       0, '0, 0}
      };

      foreach (plan[i]) begin
         if (plan[i].fill) begin
            for (int fr = 0; fr < N; fr++)
               for (int fc = 0; fc < N; fc++)
                  send_request(plan[i].op, IDX_W'(fr), IDX_W'(fc), plan[i].value,
                               0, '0, 0);
         end else begin
            send_request(plan[i].op, plan[i].row, plan[i].col, plan[i].value,
                         plan[i].typed, plan[i].want, plan[i].want_sat);
         end
      end
      drain_results();

      // Random rounds: a batch of loads (sometimes a whole matrix) then usually a compute.
      random_items = 0;
      paused = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (!paused && random_items >= 24) begin
            paused = 1;
            drain_results();
         end
         sender_calm = (random_items < 20);
         if ($urandom_range(0, 9) == 0) begin
            op = load_ops[$urandom_range(0, 2)];
            for (int fr = 0; fr < N; fr++) begin
               for (int fc = 0; fc < N; fc++) begin
                  send_request(op, IDX_W'(fr), IDX_W'(fc), rand_value(), 0, '0, 0);
                  random_items++;
               end
            end
         end else begin
            loads = $urandom_range(0, 12);
            repeat (loads) begin
               op = load_ops[$urandom_range(0, 2)];
               if ($urandom_range(0, 9) == 0) begin
                  r = IDX_W'($urandom_range(0, 7));
                  c = IDX_W'($urandom_range(0, 7));
               end else begin
                  r = IDX_W'($urandom_range(0, N-1));
                  c = IDX_W'($urandom_range(0, N-1));
               end
               send_request(op, r, c, rand_value(), 0, '0, 0);
               if (r < N && c < N) random_items++;
            end
         end
         if ($urandom_range(0, 9) != 0) begin
            send_request(OP_COMPUTE, IDX_W'($urandom_range(0, 7)),
                         IDX_W'($urandom_range(0, 7)), $urandom, 0, '0, 0);
            random_items++;
         end
      end
      sender_calm = 0;

      // Let the last results drain, then allow a margin for anything stray.
      drain_results();
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/smmac_pkg.sv
rtl/smmac_req_if.sv
rtl/smmac_rsp_if.sv
rtl/smmac_ram.sv
rtl/smmac_front.sv
rtl/smmac_back.sv
rtl/small_matrix_multiply_accumulate_unit.sv
tb/sv/tb_small_matrix_multiply_accumulate_unit.sv
